// ----- design/vks_pkg.sv -----
// ----------------------------------------------------------------------------
// vks_pkg
// Shared widths, constants and the arctangent table of the kinematics step.
// ----------------------------------------------------------------------------
`default_nettype none

package vks_pkg;

    localparam int MUL_A_W = 34;   // signed multiplicand
    localparam int MUL_B_W = 30;   // unsigned multiplier, one bit per cycle
    localparam int MUL_P_W = MUL_A_W + MUL_B_W + 1;
    localparam int DIV_N_W = 64;   // signed dividend, one quotient bit per cycle
    localparam int DIV_D_W = 27;   // unsigned constant divisor
    localparam int CORD_W  = 34;
    localparam int ATAN_LEN = 24;
    localparam int ATAN_IDX_W = 5;

    typedef logic signed [MUL_A_W-1:0] mul_a_t;
    typedef logic        [MUL_B_W-1:0] mul_b_t;
    typedef logic signed [MUL_P_W-1:0] mul_p_t;
    typedef logic signed [DIV_N_W-1:0] div_n_t;
    typedef logic        [DIV_D_W-1:0] div_d_t;
    typedef logic signed [CORD_W-1:0]  cord_t;

    localparam logic signed [15:0] RUD_LIM     = 16'sd25600;
    localparam div_d_t             TURN_DIV    = 27'd94371840;
    localparam div_d_t             VR_DIV      = 27'd512000;
    localparam div_d_t             DIVE_DIV    = 27'd10240;
    localparam div_d_t             RISE_DIV    = 27'd1024;
    localparam mul_b_t             GAIN_Q30    = 30'd652032874;

    localparam logic [7:0] CFG_DRIFT_X    = 8'd0;
    localparam logic [7:0] CFG_DRIFT_Y    = 8'd1;
    localparam logic [7:0] CFG_DRIFT_TURN = 8'd2;
    localparam logic [7:0] CFG_RISE_RATE  = 8'd3;

    // atan(2^-i) as a fraction of a full turn, 2^32 per turn
    localparam logic [31:0] ATAN_TBL [ATAN_LEN] = '{
        32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43,
        32'h0145D7E1, 32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F,
        32'h000A2F98, 32'h000517CC, 32'h00028BE6, 32'h000145F3, 32'h0000A2F9,
        32'h0000517C, 32'h000028BE, 32'h0000145F, 32'h00000A2F, 32'h00000517,
        32'h0000028B, 32'h00000145, 32'h000000A2, 32'h00000051
    };

endpackage

`default_nettype wire

// ----- design/vks_mul.sv -----
// ----------------------------------------------------------------------------
// vks_mul
// Bit-serial shift-add multiplier: signed a times unsigned b, one bit of b
// per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module vks_mul (
    input  wire               aclk,
    input  wire               aresetn,
    input  wire               start,
    input  vks_pkg::mul_a_t   a,
    input  vks_pkg::mul_b_t   b,
    output logic              done,
    output vks_pkg::mul_p_t   p
);

    localparam int AW = vks_pkg::MUL_A_W;
    localparam int BW = vks_pkg::MUL_B_W;

    logic [AW-1:0]    mag_reg;
    logic [AW+BW-1:0] acc_reg;
    logic [AW+BW-1:0] acc_next;
    logic [AW:0]      sum;
    logic             neg_reg;
    logic [4:0]       cnt_reg;
    logic             busy_reg;
    logic             done_reg;

    assign sum      = {1'b0, acc_reg[AW+BW-1:BW]} + (acc_reg[0] ? {1'b0, mag_reg} : '0);
    assign acc_next = {sum, acc_reg[BW-1:1]};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                mag_reg  <= a[AW-1] ? AW'(-a) : AW'(a);
                neg_reg  <= a[AW-1];
                acc_reg  <= {{AW{1'b0}}, b};
                cnt_reg  <= '0;
                busy_reg <= 1'b1;
            end else if (busy_reg) begin
                acc_reg <= acc_next;
                cnt_reg <= cnt_reg + 5'd1;
                if (cnt_reg == 5'(BW - 1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    assign done = done_reg;
    assign p    = neg_reg ? -$signed({1'b0, acc_reg}) : $signed({1'b0, acc_reg});

endmodule

`default_nettype wire

// ----- design/vks_div.sv -----
// ----------------------------------------------------------------------------
// vks_div
// Restoring divider, one quotient bit per cycle, floor division of a signed
// dividend by a positive divisor.
// ----------------------------------------------------------------------------
`default_nettype none

module vks_div (
    input  wire               aclk,
    input  wire               aresetn,
    input  wire               start,
    input  vks_pkg::div_n_t   n,
    input  vks_pkg::div_d_t   d,
    output logic              done,
    output vks_pkg::div_n_t   q
);

    localparam int NW = vks_pkg::DIV_N_W;
    localparam int DW = vks_pkg::DIV_D_W;

    logic [NW-1:0] quo_reg;
    logic [DW-1:0] rem_reg;
    logic [DW-1:0] d_reg;
    logic [DW:0]   trial;
    logic          ge;
    logic          neg_reg;
    logic [5:0]    cnt_reg;
    logic          busy_reg;
    logic          done_reg;

    assign trial = {rem_reg, quo_reg[NW-1]};
    assign ge    = trial >= {1'b0, d_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                quo_reg  <= n[NW-1] ? NW'(-n) : NW'(n);
                neg_reg  <= n[NW-1];
                rem_reg  <= '0;
                d_reg    <= d;
                cnt_reg  <= '0;
                busy_reg <= 1'b1;
            end else if (busy_reg) begin
                rem_reg <= ge ? DW'(trial - {1'b0, d_reg}) : trial[DW-1:0];
                quo_reg <= {quo_reg[NW-2:0], ge};
                cnt_reg <= cnt_reg + 6'd1;
                if (cnt_reg == 6'(NW - 1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // negative dividend: floor is minus the ceiling of the magnitude quotient
    assign done = done_reg;
    assign q    = neg_reg ? -$signed(quo_reg + NW'(rem_reg != '0)) : $signed(quo_reg);

endmodule

`default_nettype wire

// ----- design/vks_cordic.sv -----
// ----------------------------------------------------------------------------
// vks_cordic
// Iterative rotation CORDIC: rotates (vr * 2^14, 0) by a binary angle, one
// micro-rotation per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module vks_cordic #(
    parameter int ANGLE_BITS   = 16,
    parameter int CORDIC_STEPS = 16
) (
    input  wire                    aclk,
    input  wire                    aresetn,
    input  wire                    start,
    input  wire signed [16:0]      vr,
    input  wire [ANGLE_BITS-1:0]   phi,
    output logic                   done,
    output vks_pkg::cord_t         x,
    output vks_pkg::cord_t         y
);

    localparam int CW = vks_pkg::CORD_W;
    localparam logic signed [CW-1:0] QTR  = CW'(64'sd1073741824);
    localparam logic signed [CW-1:0] HALF = CW'(64'sd2147483648);

    logic signed [CW-1:0] x_reg, y_reg, z_reg;
    logic signed [CW-1:0] x0, z0, xs, ys, at;
    logic [31:0]          zs;
    logic [vks_pkg::ATAN_IDX_W-1:0] cnt_reg;
    logic                 busy_reg;
    logic                 done_reg;

    assign zs = {phi, {(32 - ANGLE_BITS){1'b0}}};
    assign z0 = CW'($signed(zs));
    assign x0 = CW'($signed({vr, 14'b0}));
    assign xs = x_reg >>> cnt_reg;
    assign ys = y_reg >>> cnt_reg;
    assign at = CW'(vks_pkg::ATAN_TBL[cnt_reg]);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                y_reg    <= '0;
                cnt_reg  <= '0;
                busy_reg <= 1'b1;
                // fold angles beyond a quarter turn into the right half plane
                if (z0 > QTR) begin
                    x_reg <= -x0;
                    z_reg <= z0 - HALF;
                end else if (z0 < -QTR) begin
                    x_reg <= -x0;
                    z_reg <= z0 + HALF;
                end else begin
                    x_reg <= x0;
                    z_reg <= z0;
                end
            end else if (busy_reg) begin
                if (!z_reg[CW-1]) begin
                    x_reg <= x_reg - ys;
                    y_reg <= y_reg + xs;
                    z_reg <= z_reg - at;
                end else begin
                    x_reg <= x_reg + ys;
                    y_reg <= y_reg - xs;
                    z_reg <= z_reg + at;
                end
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == vks_pkg::ATAN_IDX_W'(CORDIC_STEPS - 1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    assign done = done_reg;
    assign x    = x_reg;
    assign y    = y_reg;

endmodule

`default_nettype wire

// ----- design/vehicle_kinematics_step_core.sv -----
// Each item runs seven serial multiplies, three serial divides, a CORDIC rotation
// and one post on the shared serial units.
// One item at a time: a new one is taken only once the last is posted; a finished
// result waits in the output register and holds the sequencer until taken.
// Reset (aresetn low, synchronous): positions, heading, depth, time and the
// four configuration registers clear to zero; no result is pending.
// ----------------------------------------------------------------------------
// vehicle_kinematics_step_core
// One simulation step per item: turn, reduced speed, rotated velocity and
// integration of position, heading, depth and elapsed time.
// ----------------------------------------------------------------------------
`default_nettype none

module vehicle_kinematics_step_core #(
    parameter int ANGLE_BITS   = 16,
    parameter int POS_BITS     = 32,
    parameter int CORDIC_STEPS = 16
) (
    input  wire          aclk,
    input  wire          aresetn,
    input  wire          s_tvalid,
    output logic         s_tready,
    // speed_cmd[15:0], rudder_cmd[31:16], step_time[47:32], elevator_cmd[63:48]
    input  wire [63:0]   s_tdata,
    output logic         m_tvalid,
    input  wire          m_tready,
    // pos_x[31:0], pos_y[63:32], heading_out[79:64], speed_out[95:80],
    // depth_out[126:96], elapsed[158:127], zero pad[159]
    output logic [159:0] m_tdata,
    input  wire          cfg_valid,
    output logic         cfg_ready,
    input  wire [7:0]    cfg_index,
    input  wire [15:0]   cfg_data
);

    typedef enum logic [3:0] {
        ST_IDLE, ST_T_MUL, ST_T_DIV, ST_V_MUL, ST_V_DIV, ST_ROT, ST_GX_MUL,
        ST_GY_MUL, ST_PX_MUL, ST_PY_MUL, ST_D_MUL, ST_D_DIV, ST_FIN
    } state_t;

    localparam int CW = vks_pkg::CORD_W;

    state_t state_reg;
    logic   go_reg;

    logic signed [15:0] drift_x_reg, drift_y_reg, drift_turn_reg, rise_reg;
    logic [POS_BITS-1:0]   east_reg, north_reg;
    logic [ANGLE_BITS-1:0] heading_reg, turn_reg;
    logic [30:0]           depth_reg;
    logic [31:0]           time_reg;

    logic signed [15:0] v_reg, rc_reg, e_reg;
    logic [15:0]        dt_reg;
    logic signed [16:0] vr_reg;
    logic signed [CW-1:0] vn_reg, ve_reg;
    logic               m_tvalid_reg;
    logic [159:0]       m_tdata_reg;

    // input decode
    logic signed [15:0] v_in, r_in, e_in, r_clamp;
    assign v_in = $signed(s_tdata[15:0]);
    assign r_in = $signed(s_tdata[31:16]);
    assign e_in = $signed(s_tdata[63:48]);
    assign r_clamp = (r_in > vks_pkg::RUD_LIM) ? vks_pkg::RUD_LIM :
                     (r_in < -vks_pkg::RUD_LIM) ? -vks_pkg::RUD_LIM : r_in;

    // shared units
    logic mul_start, div_start, cor_start;
    logic mul_done, div_done, cor_done;
    vks_pkg::mul_a_t mul_a;
    vks_pkg::mul_b_t mul_b;
    vks_pkg::mul_p_t mul_p;
    vks_pkg::div_n_t div_n;
    vks_pkg::div_d_t div_d;
    vks_pkg::div_n_t div_q;
    vks_pkg::cord_t  cor_x, cor_y;

    logic               is_mul, is_div;
    logic               v_pos;
    logic [15:0]        abs_r;
    logic signed [21:0] turn_rate;
    vks_pkg::div_n_t    p64;

    assign v_pos     = (v_reg > 16'sd0);
    assign abs_r     = rc_reg[15] ? 16'(-rc_reg) : 16'(rc_reg);
    assign turn_rate = (22'(rc_reg) <<< 5) + (22'(rc_reg) <<< 3) + 22'(drift_turn_reg);
    assign p64       = vks_pkg::DIV_N_W'(mul_p);

    assign is_mul = (state_reg == ST_T_MUL) || (state_reg == ST_V_MUL) ||
                    (state_reg == ST_GX_MUL) || (state_reg == ST_GY_MUL) ||
                    (state_reg == ST_PX_MUL) || (state_reg == ST_PY_MUL) ||
                    (state_reg == ST_D_MUL);
    assign is_div = (state_reg == ST_T_DIV) || (state_reg == ST_V_DIV) ||
                    (state_reg == ST_D_DIV);

    assign mul_start = is_mul && !go_reg;
    assign div_start = is_div && !go_reg;
    assign cor_start = (state_reg == ST_ROT) && !go_reg;

    always_comb begin
        mul_a = '0;
        mul_b = vks_pkg::MUL_B_W'(dt_reg);
        case (state_reg)
            ST_T_MUL:  mul_a = vks_pkg::MUL_A_W'(turn_rate);
            ST_V_MUL: begin
                mul_a = vks_pkg::MUL_A_W'(v_reg);
                mul_b = vks_pkg::MUL_B_W'(abs_r);
            end
            ST_GX_MUL: begin
                mul_a = cor_x;
                mul_b = vks_pkg::GAIN_Q30;
            end
            ST_GY_MUL: begin
                mul_a = cor_y;
                mul_b = vks_pkg::GAIN_Q30;
            end
            ST_PX_MUL: mul_a = ve_reg + (CW'(drift_x_reg) <<< 14);
            ST_PY_MUL: mul_a = vn_reg + (CW'(drift_y_reg) <<< 14);
            ST_D_MUL:  mul_a = v_pos ? vks_pkg::MUL_A_W'(e_reg)
                                     : -vks_pkg::MUL_A_W'(rise_reg);
            default:   mul_a = '0;
        endcase
    end

    always_comb begin
        div_n = '0;
        div_d = vks_pkg::TURN_DIV;
        case (state_reg)
            ST_T_DIV: begin
                div_n = (p64 <<< ANGLE_BITS) + 64'sd47185920;
                div_d = vks_pkg::TURN_DIV;
            end
            ST_V_DIV: begin
                div_n = (p64 <<< 4) + p64 + 64'sd256000;
                div_d = vks_pkg::VR_DIV;
            end
            ST_D_DIV: begin
                div_n = p64 + (v_pos ? 64'sd5120 : 64'sd512);
                div_d = v_pos ? vks_pkg::DIVE_DIV : vks_pkg::RISE_DIV;
            end
            default: div_n = '0;
        endcase
    end

    vks_mul u_mul (
        .aclk(aclk), .aresetn(aresetn), .start(mul_start),
        .a(mul_a), .b(mul_b), .done(mul_done), .p(mul_p)
    );

    vks_div u_div (
        .aclk(aclk), .aresetn(aresetn), .start(div_start),
        .n(div_n), .d(div_d), .done(div_done), .q(div_q)
    );

    vks_cordic #(.ANGLE_BITS(ANGLE_BITS), .CORDIC_STEPS(CORDIC_STEPS)) u_cordic (
        .aclk(aclk), .aresetn(aresetn), .start(cor_start),
        .vr(vr_reg), .phi(heading_reg - turn_reg),
        .done(cor_done), .x(cor_x), .y(cor_y)
    );

    // result assembly
    logic [ANGLE_BITS-1:0] heading_new;
    logic [31:0]           hd32;
    logic [31:0]           time_new;
    logic [15:0]           speed_abs;
    logic signed [32:0]    depth_sum;
    logic signed [CW-1:0]  gain_out;
    logic signed [POS_BITS-1:0] pos_step;

    assign heading_new = heading_reg + turn_reg;
    assign hd32        = 32'(heading_new) << (32 - ANGLE_BITS);
    assign time_new    = time_reg + 32'(dt_reg);
    assign speed_abs   = vr_reg[16] ? 16'(-vr_reg) : 16'(vr_reg);
    assign depth_sum   = $signed({2'b00, depth_reg}) + 33'(div_q);
    assign gain_out    = CW'((mul_p + 65'sd536870912) >>> 30);
    assign pos_step    = POS_BITS'((mul_p + 65'sd8388608) >>> 24);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            go_reg         <= 1'b0;
            m_tvalid_reg   <= 1'b0;
            drift_x_reg    <= '0;
            drift_y_reg    <= '0;
            drift_turn_reg <= '0;
            rise_reg       <= '0;
            east_reg       <= '0;
            north_reg      <= '0;
            heading_reg    <= '0;
            depth_reg      <= '0;
            time_reg       <= '0;
        end else begin
            if (cfg_valid) begin
                case (cfg_index)
                    vks_pkg::CFG_DRIFT_X:    drift_x_reg    <= $signed(cfg_data);
                    vks_pkg::CFG_DRIFT_Y:    drift_y_reg    <= $signed(cfg_data);
                    vks_pkg::CFG_DRIFT_TURN: drift_turn_reg <= $signed(cfg_data);
                    vks_pkg::CFG_RISE_RATE:  rise_reg       <= $signed(cfg_data);
                    default: ;
                endcase
            end

            // the final state posts its own result when the output frees up
            if (m_tvalid_reg && m_tready && (state_reg != ST_FIN)) begin
                m_tvalid_reg <= 1'b0;
            end

            if (mul_start || div_start || cor_start) begin
                go_reg <= 1'b1;
            end

            case (state_reg)
                ST_IDLE: begin
                    if (s_tvalid) begin
                        v_reg     <= v_in;
                        dt_reg    <= s_tdata[47:32];
                        rc_reg    <= (v_in == 16'sd0) ? 16'sd0 : r_clamp;
                        e_reg     <= (v_in == 16'sd0) ? 16'sd0 : e_in;
                        state_reg <= ST_T_MUL;
                    end
                end
                ST_T_MUL: if (mul_done) begin
                    go_reg    <= 1'b0;
                    state_reg <= ST_T_DIV;
                end
                ST_T_DIV: if (div_done) begin
                    go_reg    <= 1'b0;
                    turn_reg  <= div_q[ANGLE_BITS-1:0];
                    state_reg <= ST_V_MUL;
                end
                ST_V_MUL: if (mul_done) begin
                    go_reg    <= 1'b0;
                    state_reg <= ST_V_DIV;
                end
                ST_V_DIV: if (div_done) begin
                    go_reg    <= 1'b0;
                    vr_reg    <= 17'(v_reg) - 17'(div_q);
                    state_reg <= ST_ROT;
                end
                ST_ROT: if (cor_done) begin
                    go_reg    <= 1'b0;
                    state_reg <= ST_GX_MUL;
                end
                ST_GX_MUL: if (mul_done) begin
                    go_reg    <= 1'b0;
                    vn_reg    <= gain_out;
                    state_reg <= ST_GY_MUL;
                end
                ST_GY_MUL: if (mul_done) begin
                    go_reg    <= 1'b0;
                    ve_reg    <= gain_out;
                    state_reg <= ST_PX_MUL;
                end
                ST_PX_MUL: if (mul_done) begin
                    go_reg    <= 1'b0;
                    east_reg  <= east_reg + pos_step;
                    state_reg <= ST_PY_MUL;
                end
                ST_PY_MUL: if (mul_done) begin
                    go_reg    <= 1'b0;
                    north_reg <= north_reg + pos_step;
                    state_reg <= ST_D_MUL;
                end
                ST_D_MUL: if (mul_done) begin
                    go_reg    <= 1'b0;
                    state_reg <= ST_D_DIV;
                end
                ST_D_DIV: if (div_done) begin
                    go_reg <= 1'b0;
                    if (depth_sum < 33'sd0) begin
                        depth_reg <= '0;
                    end else if (depth_sum > 33'sd2147483647) begin
                        depth_reg <= 31'h7FFFFFFF;
                    end else begin
                        depth_reg <= depth_sum[30:0];
                    end
                    state_reg <= ST_FIN;
                end
                ST_FIN: begin
                    // hold until the output register is free
                    if (!m_tvalid_reg || m_tready) begin
                        heading_reg  <= heading_new;
                        time_reg     <= time_new;
                        m_tvalid_reg <= 1'b1;
                        m_tdata_reg  <= {1'b0, time_new, depth_reg, speed_abs,
                                         hd32[31:16], 32'(north_reg), 32'(east_reg)};
                        state_reg    <= ST_IDLE;
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    assign s_tready  = (state_reg == ST_IDLE);
    assign m_tvalid  = m_tvalid_reg;
    assign m_tdata   = m_tdata_reg;
    assign cfg_ready = 1'b1;

endmodule

`default_nettype wire

// ----- design/vks_chk.sv -----
// ----------------------------------------------------------------------------
// vks_chk
// Port-level checks on the kinematics step core, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module vks_chk (
    input wire         aclk,
    input wire         aresetn,
    input wire         s_tvalid,
    input wire         s_tready,
    input wire         m_tvalid,
    input wire         m_tready,
    input wire [159:0] m_tdata
);

    a_hold_valid: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid)
        else $error("result dropped while stalled");

    a_hold_data: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> $stable(m_tdata))
        else $error("result changed while stalled");

    a_one_item: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("second item taken while one is at work");

    a_result_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid) |-> $past(!s_tready))
        else $error("result appeared without an item at work");

endmodule

bind vehicle_kinematics_step_core vks_chk u_vks_chk (
    .aclk(aclk), .aresetn(aresetn), .s_tvalid(s_tvalid), .s_tready(s_tready),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
);

`default_nettype wire

// ----- verif/tb_vehicle_kinematics_step_core.sv -----
// ----------------------------------------------------------------------------
// tb_vehicle_kinematics_step_core
// Drives simulation steps with random bursts and gaps, stalls the result side
// on its own pattern, and compares every result field against a fixed-point
// model of the step kept in a small scoreboard class.
// ----------------------------------------------------------------------------
module tb_vehicle_kinematics_step_core;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int LAT = 500;
    localparam int HOLD_CYCLES = 4 * LAT;
    localparam int WATCHDOG_LIMIT = 20000;
    localparam int N_RANDOM = 400;
    localparam logic [7:0] CFG_BAD_INDEX = 8'd7;

    typedef struct packed {
        logic [15:0] elevator_cmd;
        logic [15:0] step_time;
        logic [15:0] rudder_cmd;
        logic [15:0] speed_cmd;
    } step_t;

    typedef struct {
        logic [31:0] pos_x;
        logic [31:0] pos_y;
        logic [15:0] heading_out;
        logic [15:0] speed_out;
        logic [30:0] depth_out;
        logic [31:0] elapsed;
    } state_out_t;

    class kinematics_scoreboard;
        longint drift_x, drift_y, drift_turn, rise_rate;
        longint east, north, heading, depth, tacc;
        state_out_t pending[$];
        int errors;
        int results;

        function new();
            errors = 0;
            results = 0;
            drift_x = 0; drift_y = 0; drift_turn = 0; rise_rate = 0;
            east = 0; north = 0; heading = 0; depth = 0; tacc = 0;
        endfunction

        function void set_reg(logic [7:0] idx, logic [15:0] val);
            case (idx)
                vks_pkg::CFG_DRIFT_X:    drift_x = longint'($signed(val));
                vks_pkg::CFG_DRIFT_Y:    drift_y = longint'($signed(val));
                vks_pkg::CFG_DRIFT_TURN: drift_turn = longint'($signed(val));
                vks_pkg::CFG_RISE_RATE:  rise_rate = longint'($signed(val));
                default: ;
            endcase
        endfunction

        function longint floor_div(longint n, longint d);
            if (n >= 0) return n / d;
            return -((-n + d - 1) / d);
        endfunction

        function longint round_div(longint n, longint d);
            return floor_div(n + d / 2, d);
        endfunction

        function void note_step(step_t s);
            longint v, r, dt, e, turn, vr, x, y, z, xs, ys, vn, ve, dx, dy, dl, d;
            state_out_t o;
            v = longint'($signed(s.speed_cmd));
            r = longint'($signed(s.rudder_cmd));
            dt = longint'(s.step_time);
            e = longint'($signed(s.elevator_cmd));
            if (r > 25600) r = 25600;
            if (r < -25600) r = -25600;
            if (v == 0) begin
                r = 0;
                e = 0;
            end
            turn = round_div((r * 40 + drift_turn) * dt * 65536, 94371840) & 64'hFFFF;
            vr = v - round_div(v * (r < 0 ? -r : r) * 17, 512000);
            z = longint'($signed(32'(((heading - turn) & 64'hFFFF) << 16)));
            x = vr * 16384;
            y = 0;
            if (z > (64'sd1 << 30)) begin
                x = -x;
                z -= 64'sd1 << 31;
            end else if (z < -(64'sd1 << 30)) begin
                x = -x;
                z += 64'sd1 << 31;
            end
            for (int i = 0; i < 16; i++) begin
                xs = x >>> i;
                ys = y >>> i;
                if (z >= 0) begin
                    x = x - ys; y = y + xs; z -= longint'(vks_pkg::ATAN_TBL[i]);
                end else begin
                    x = x + ys; y = y - xs; z += longint'(vks_pkg::ATAN_TBL[i]);
                end
            end
            vn = (x * 652032874 + (64'sd1 << 29)) >>> 30;
            ve = (y * 652032874 + (64'sd1 << 29)) >>> 30;
            dx = ((ve + drift_x * 16384) * dt + (64'sd1 << 23)) >>> 24;
            dy = ((vn + drift_y * 16384) * dt + (64'sd1 << 23)) >>> 24;
            east = (east + dx) & 64'hFFFFFFFF;
            north = (north + dy) & 64'hFFFFFFFF;
            heading = (heading + turn) & 64'hFFFF;
            tacc = (tacc + dt) & 64'hFFFFFFFF;
            if (v > 0) dl = round_div(e * dt, 10240);
            else dl = round_div(-rise_rate * dt, 1024);
            d = depth + dl;
            if (d < 0) d = 0;
            if (d > 64'sd2147483647) d = 64'sd2147483647;
            depth = d;
            o.pos_x = east[31:0];
            o.pos_y = north[31:0];
            o.heading_out = heading[15:0];
            o.speed_out = vr < 0 ? 16'(-vr) : 16'(vr);
            o.depth_out = depth[30:0];
            o.elapsed = tacc[31:0];
            pending.push_back(o);
        endfunction

        function void check_result(logic [159:0] t);
            state_out_t w;
            results++;
            if (pending.size() == 0) begin
                $error("unexpected result item %h", t);
                errors++;
                return;
            end
            w = pending.pop_front();
            if (t[31:0] !== w.pos_x) begin
                $error("pos_x exp %h got %h", w.pos_x, t[31:0]); errors++;
            end
            if (t[63:32] !== w.pos_y) begin
                $error("pos_y exp %h got %h", w.pos_y, t[63:32]); errors++;
            end
            if (t[79:64] !== w.heading_out) begin
                $error("heading_out exp %h got %h", w.heading_out, t[79:64]); errors++;
            end
            if (t[95:80] !== w.speed_out) begin
                $error("speed_out exp %h got %h", w.speed_out, t[95:80]); errors++;
            end
            if (t[126:96] !== w.depth_out) begin
                $error("depth_out exp %h got %h", w.depth_out, t[126:96]); errors++;
            end
            if (t[158:127] !== w.elapsed) begin
                $error("elapsed exp %h got %h", w.elapsed, t[158:127]); errors++;
            end
        endfunction
    endclass

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic s_tvalid = 1'b0;
    logic s_tready;
    logic [63:0] s_tdata = '0;
    logic m_tvalid;
    logic m_tready = 1'b0;
    logic [159:0] m_tdata;
    logic cfg_valid = 1'b0;
    logic cfg_ready;
    logic [7:0] cfg_index = '0;
    logic [15:0] cfg_data = '0;

    kinematics_scoreboard sb = new();
    int steps_sent = 0;
    int idle_cycles = 0;
    bit hold_req = 1'b0;
    bit hold_seen = 1'b0;
    int hold_left = 0;

    always #5 aclk = ~aclk;

    vehicle_kinematics_step_core dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    // receiver: own stall pattern, plus one long hold-off counted here
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) sb.check_result(m_tdata);
        if (hold_req && !hold_seen) begin
            hold_seen <= 1'b1;
            hold_left <= HOLD_CYCLES;
            m_tready <= 1'b0;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
            m_tready <= 1'b0;
        end else if ($urandom_range(0, 3) == 0) begin
            m_tready <= $urandom_range(0, 1);
        end
    end

    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles > WATCHDOG_LIMIT) begin
            $display("tb: failure");
            $finish;
        end
    end

    task automatic write_reg(logic [7:0] idx, logic [15:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        do @(posedge aclk); while (!cfg_ready);
        sb.set_reg(idx, val);
        cfg_valid <= 1'b0;
    endtask

    task automatic send_step(step_t s);
        s_tvalid <= 1'b1;
        s_tdata <= s;
        do @(posedge aclk); while (!s_tready);
        sb.note_step(s);
        steps_sent++;
    endtask

    task automatic pause_sender();
        s_tvalid <= 1'b0;
        repeat ($urandom_range(1, 40)) @(posedge aclk);
    endtask

    task automatic drain();
        s_tvalid <= 1'b0;
        while (sb.pending.size() != 0) @(posedge aclk);
        repeat (LAT) @(posedge aclk);
    endtask

    function automatic logic [15:0] pick16();
        case ($urandom_range(0, 7))
            0: return 16'h8000;
            1: return 16'h7FFF;
            2: return 16'h0000;
            3: return 16'(signed'($urandom_range(0, 51200)) - 25600);
            4: return 16'($urandom_range(0, 2560));
            default: return 16'($urandom);
        endcase
    endfunction

    function automatic step_t random_step();
        step_t s;
        s.speed_cmd = ($urandom_range(0, 9) == 0) ? 16'h0 : pick16();
        s.rudder_cmd = pick16();
        s.step_time = ($urandom_range(0, 3) == 0) ? 16'($urandom) : 16'($urandom_range(0, 2048));
        s.elevator_cmd = pick16();
        return s;
    endfunction

    initial begin
        step_t s;
        int burst;
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        write_reg(vks_pkg::CFG_DRIFT_X, 16'h0000);
        write_reg(CFG_BAD_INDEX, 16'h1234);   // out-of-range index: ignored

        // corners: extreme fields, zero speed, saturated rudder
        send_step('{16'h7FFF, 16'hFFFF, 16'h7FFF, 16'h7FFF});
        send_step('{16'h8000, 16'hFFFF, 16'h8000, 16'h8000});
        send_step('{16'h7FFF, 16'h0400, 16'h8000, 16'h0000});
        send_step('{16'h0000, 16'h0000, 16'h0000, 16'h0000});
        send_step('{16'h1234, 16'h0400, 16'h6400, 16'h0100});
        send_step('{16'h8000, 16'h0400, 16'h9C00, 16'hFF00});
        send_step('{16'h7FFF, 16'hFFFF, 16'h0000, 16'h8000});
        send_step('{16'h8000, 16'hFFFF, 16'h0000, 16'h8000});
        for (int i = 0; i < 10; i++) send_step(random_step());
        drain();

        write_reg(vks_pkg::CFG_DRIFT_X, 16'h7FFF);
        write_reg(vks_pkg::CFG_DRIFT_Y, 16'h8000);
        write_reg(vks_pkg::CFG_DRIFT_TURN, 16'h7FFF);
        write_reg(vks_pkg::CFG_RISE_RATE, 16'h8000);
        send_step('{16'h0000, 16'hFFFF, 16'h0000, 16'h0000});
        send_step('{16'h0000, 16'hFFFF, 16'h0000, 16'h8000});
        send_step('{16'h7FFF, 16'hFFFF, 16'h1000, 16'h0100});

        // fill the block while the receiver holds off
        hold_req = 1'b1;
        for (int i = 0; i < 4; i++) send_step(random_step());
        drain();

        for (int ph = 0; ph < 4; ph++) begin
            write_reg(vks_pkg::CFG_DRIFT_X, ph == 3 ? 16'h8000 : pick16());
            write_reg(vks_pkg::CFG_DRIFT_Y, ph == 3 ? 16'h7FFF : pick16());
            write_reg(vks_pkg::CFG_DRIFT_TURN, ph == 3 ? 16'h8000 : pick16());
            write_reg(vks_pkg::CFG_RISE_RATE, ph == 3 ? 16'h7FFF : pick16());
            for (int n = 0; n < N_RANDOM / 4; n += burst) begin
                burst = $urandom_range(1, 12);
                for (int k = 0; k < burst; k++) begin
                    s = random_step();
                    send_step(s);
                end
                if ($urandom_range(0, 2) != 0) pause_sender();
            end
            drain();
        end

        $display("covered %0d steps, %0d results, drift and rise settings in 6 phases",
                 steps_sent, sb.results);
        if (sb.errors == 0 && sb.pending.size() == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end
endmodule
